FILE: src/ggac_pkg.sv
// Shared types, codes and helpers of the grouped genotype allele counter.
// Used by the controller, the datapath and the top level; depends on nothing.
package ggac_pkg;

  // Field widths fixed by the stream format
  localparam int unsigned GIDX_W   = 12;
  localparam int unsigned GVAL_W   = 5;
  localparam int unsigned GENO_W   = 8;
  localparam int unsigned LABEL_W  = 5;
  localparam int unsigned NIND_W   = 13;
  localparam int unsigned NGRP_W   = 5;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned GID_W    = 4;
  localparam int unsigned COUNT_W  = 14;
  localparam int unsigned LANES    = 4;
  localparam int unsigned IN_DW    = 32;
  localparam int unsigned OUT_DW   = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Item kinds carried on s_tuser
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_GENO = 1'b1;

  // Configuration register indexes
  localparam logic CFG_NUM_IND = 1'b0;
  localparam logic CFG_NUM_GRP = 1'b1;

  // Genotype code for a missing call
  localparam logic [1:0] CODE_MISSING = 2'd3;

  typedef enum logic [1:0] {
    ST_COUNT,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_load;
    logic take_byte;
    logic drain_load;
    logic clear_counts;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic row_end;
    logic drain_last;
    logic out_free;
  } dp_status_t;

  // Allele weight of one 2-bit genotype code
  function automatic logic [1:0] geno_weight(input logic [1:0] code, input logic flip);
    logic [1:0] w;
    if (code == CODE_MISSING) begin
      w = 2'd0;
    end else if (flip) begin
      w = 2'd2 - code;
    end else begin
      w = code;
    end
    return w;
  endfunction

endpackage

FILE: src/ggac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the individual-to-group label table.
module ggac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/ggac_ctrl.sv
// Controller of the allele counter: counting, flush of the last byte, drain.
// Depends on ggac_pkg for the state type and the command/status structs.
module ggac_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tuser,
  output logic                  s_tready,
  input  ggac_pkg::dp_status_t  st,
  output ggac_pkg::ctrl_cmd_t   cmd
);

  ggac_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ggac_pkg::ST_COUNT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ggac_pkg::ST_COUNT: begin
        if (s_tvalid && s_tuser == ggac_pkg::CMD_GENO && st.row_end) begin
          state_next = ggac_pkg::ST_FLUSH;
        end
      end
      ggac_pkg::ST_FLUSH: begin
        state_next = ggac_pkg::ST_DRAIN;
      end
      ggac_pkg::ST_DRAIN: begin
        if (st.out_free && st.drain_last) begin
          state_next = ggac_pkg::ST_COUNT;
        end
      end
      default: begin
        state_next = ggac_pkg::ST_COUNT;
      end
    endcase
  end

  // Outputs
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      ggac_pkg::ST_COUNT: begin
        s_tready      = 1'b1;
        cmd.take_load = s_tvalid && s_tuser == ggac_pkg::CMD_LOAD;
        cmd.take_byte = s_tvalid && s_tuser == ggac_pkg::CMD_GENO;
      end
      ggac_pkg::ST_FLUSH: begin
        s_tready = 1'b0;
      end
      ggac_pkg::ST_DRAIN: begin
        cmd.drain_load   = st.out_free;
        cmd.clear_counts = st.out_free && st.drain_last;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

FILE: src/ggac_dp.sv
// Datapath of the allele counter: config registers, label table lanes,
// group counters, row position and the output register.
// Depends on ggac_pkg and ggac_ram.
module ggac_dp #(
  parameter int unsigned MAX_INDIVIDUALS = 4096,
  parameter int unsigned MAX_GROUPS      = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [ggac_pkg::CFG_W-1:0]         cfg_data,
  input  logic [ggac_pkg::GIDX_W-1:0]        group_index,
  input  logic [ggac_pkg::GVAL_W-1:0]        group_value,
  input  logic [ggac_pkg::GENO_W-1:0]        packed_genotypes,
  input  logic                               flip,
  input  ggac_pkg::ctrl_cmd_t                cmd,
  output ggac_pkg::dp_status_t               st,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ggac_pkg::GID_W-1:0]         group_id,
  output logic [ggac_pkg::COUNT_W-1:0]       allele_count,
  output logic                               last
);

  localparam int unsigned LANE_DEPTH = (MAX_INDIVIDUALS + 3) / 4;
  localparam int unsigned BP_W  = LANE_DEPTH > 1 ? $clog2(LANE_DEPTH) : 1;
  localparam int unsigned IND_W = $clog2(MAX_INDIVIDUALS + 1);
  localparam int unsigned GRP_W = $clog2(MAX_GROUPS + 1);
  localparam int unsigned GI_W  = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
  localparam int unsigned CMP_W = 8;

  // Configuration registers
  logic [ggac_pkg::NIND_W-1:0] num_individuals;
  logic [ggac_pkg::NGRP_W-1:0] num_groups;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_individuals <= ggac_pkg::NIND_W'(4096);
      num_groups      <= ggac_pkg::NGRP_W'(16);
    end else if (cfg_we) begin
      if (cfg_index == ggac_pkg::CFG_NUM_IND) begin
        num_individuals <= cfg_data[ggac_pkg::NIND_W-1:0];
      end else begin
        num_groups <= cfg_data[ggac_pkg::NGRP_W-1:0];
      end
    end
  end

  // Clamp registers into their usable ranges
  logic [IND_W-1:0] eff_ind;
  logic [GRP_W-1:0] eff_grp;
  logic [IND_W-1:0] eff_ind_m1;
  logic [IND_W-1:0] last_byte;
  logic [1:0]       last_lane;

  always_comb begin
    if (num_individuals == '0) begin
      eff_ind = IND_W'(1);
    end else if (32'(num_individuals) > 32'(MAX_INDIVIDUALS)) begin
      eff_ind = IND_W'(MAX_INDIVIDUALS);
    end else begin
      eff_ind = IND_W'(num_individuals);
    end
    if (num_groups == '0) begin
      eff_grp = GRP_W'(1);
    end else if (32'(num_groups) > 32'(MAX_GROUPS)) begin
      eff_grp = GRP_W'(MAX_GROUPS);
    end else begin
      eff_grp = GRP_W'(num_groups);
    end
    eff_ind_m1 = eff_ind - IND_W'(1);
    last_byte  = eff_ind_m1 >> 2;
    last_lane  = eff_ind_m1[1:0];
  end

  // Row position and lane mask of the byte being taken
  logic [BP_W-1:0]         byte_pos;
  logic [IND_W-1:0]        bp_ext;
  logic [ggac_pkg::LANES-1:0] lane_mask;

  assign bp_ext     = IND_W'(byte_pos);
  assign st.row_end = bp_ext >= last_byte;

  always_comb begin
    for (int s = 0; s < ggac_pkg::LANES; s++) begin
      if (bp_ext < last_byte) begin
        lane_mask[s] = 1'b1;
      end else if (bp_ext == last_byte) begin
        lane_mask[s] = 2'(s) <= last_lane;
      end else begin
        lane_mask[s] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos <= '0;
    end else if (cmd.take_byte) begin
      if (st.row_end) begin
        byte_pos <= '0;
      end else begin
        byte_pos <= byte_pos + BP_W'(1);
      end
    end
  end

  // Hold the byte while its labels are read
  logic                         upd_valid;
  logic [ggac_pkg::GENO_W-1:0]  upd_codes;
  logic                         upd_flip;
  logic [ggac_pkg::LANES-1:0]   upd_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      upd_valid <= 1'b0;
    end else begin
      upd_valid <= cmd.take_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      upd_codes <= packed_genotypes;
      upd_flip  <= flip;
      upd_mask  <= lane_mask;
    end
  end

  // Label table: one RAM per lane, indexed by byte position
  logic                           load_in_range;
  logic [ggac_pkg::LABEL_W-1:0]   load_label;
  logic [BP_W-1:0]                load_addr;
  logic [ggac_pkg::LABEL_W-1:0]   lane_label [ggac_pkg::LANES];

  assign load_in_range = 32'(group_index) < 32'(MAX_INDIVIDUALS);
  assign load_label    = group_value - ggac_pkg::LABEL_W'(1);
  assign load_addr     = BP_W'(group_index >> 2);

  for (genvar l = 0; l < ggac_pkg::LANES; l++) begin : g_lane
    ggac_ram #(
      .WIDTH (ggac_pkg::LABEL_W),
      .DEPTH (LANE_DEPTH)
    ) u_table (
      .clk   (clk),
      .we    (cmd.take_load && load_in_range && group_index[1:0] == 2'(l)),
      .waddr (load_addr),
      .wdata (load_label),
      .re    (cmd.take_byte),
      .raddr (byte_pos),
      .rdata (lane_label[l])
    );
  end

  // Group counters: each adds the weights of lanes carrying its label
  logic [ggac_pkg::COUNT_W-1:0] cnt      [MAX_GROUPS];
  logic [ggac_pkg::COUNT_W-1:0] cnt_next [MAX_GROUPS];

  always_comb begin
    logic [3:0]                 inc;
    logic [ggac_pkg::COUNT_W:0] sum;
    logic [1:0]                 w;
    for (int g = 0; g < MAX_GROUPS; g++) begin
      inc = '0;
      for (int s = 0; s < ggac_pkg::LANES; s++) begin
        w = ggac_pkg::geno_weight(upd_codes[2*s +: 2], upd_flip);
        if (upd_mask[s] && CMP_W'(lane_label[s]) == CMP_W'(g)
            && CMP_W'(lane_label[s]) < CMP_W'(eff_grp)) begin
          inc = inc + 4'(w);
        end
      end
      sum = (ggac_pkg::COUNT_W + 1)'(cnt[g]) + (ggac_pkg::COUNT_W + 1)'(inc);
      if (sum > (ggac_pkg::COUNT_W + 1)'(ggac_pkg::COUNT_MAX)) begin
        cnt_next[g] = ggac_pkg::COUNT_MAX;
      end else begin
        cnt_next[g] = sum[ggac_pkg::COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < MAX_GROUPS; g++) begin
      if (rst || cmd.clear_counts) begin
        cnt[g] <= '0;
      end else if (upd_valid) begin
        cnt[g] <= cnt_next[g];
      end
    end
  end

  // Drain index
  logic [GI_W-1:0] drain_idx;

  assign st.drain_last = GRP_W'(drain_idx) == eff_grp - GRP_W'(1);
  assign st.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      drain_idx <= '0;
    end else if (cmd.drain_load) begin
      if (st.drain_last) begin
        drain_idx <= '0;
      end else begin
        drain_idx <= drain_idx + GI_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.drain_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_load) begin
      group_id     <= ggac_pkg::GID_W'(drain_idx);
      allele_count <= cnt[drain_idx];
      last         <= st.drain_last;
    end
  end

endmodule

FILE: src/grouped_genotype_allele_counter_core.sv
// Top level of the grouped genotype allele counter.
// Depends on ggac_pkg, ggac_ctrl, ggac_dp (and ggac_ram through ggac_dp).
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------------
//   s_axis   | in  | tuser: command; tdata: group_index, group_value,
//            |     |        packed_genotypes, flip
//   m_axis   | out | tlast: last; tdata: group_id, allele_count
//   cfg      | in  | write enable, register index, write data
//
// Load and genotype beats are taken one per cycle while a row is in progress.
// The last byte of a row finishes its label read and counter update in the flush
// state, then the num_groups results drain from the output register, one per
// cycle; input tready stays low from that byte until the last result is loaded.
// Output stalls stretch the drain by the stalled cycles. Reset is synchronous;
// the label table is not cleared.
module grouped_genotype_allele_counter_core #(
  parameter int unsigned MAX_INDIVIDUALS = 4096,
  parameter int unsigned MAX_GROUPS      = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [11:0] group_index, [16:12] group_value, [24:17] packed_genotypes,
  // [25] flip, [31:26] zero
  input  logic [ggac_pkg::IN_DW-1:0]        s_tdata,
  // [0] command
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [3:0] group_id, [17:4] allele_count, [23:18] zero
  output logic [ggac_pkg::OUT_DW-1:0]       m_tdata,
  output logic                              m_tlast,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [ggac_pkg::CFG_W-1:0]        cfg_data
);

  ggac_pkg::ctrl_cmd_t  cmd;
  ggac_pkg::dp_status_t st;

  logic [ggac_pkg::GID_W-1:0]   group_id;
  logic [ggac_pkg::COUNT_W-1:0] allele_count;

  ggac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ggac_dp #(
    .MAX_INDIVIDUALS (MAX_INDIVIDUALS),
    .MAX_GROUPS      (MAX_GROUPS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .group_index      (s_tdata[11:0]),
    .group_value      (s_tdata[16:12]),
    .packed_genotypes (s_tdata[24:17]),
    .flip             (s_tdata[25]),
    .cmd              (cmd),
    .st               (st),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .group_id         (group_id),
    .allele_count     (allele_count),
    .last             (m_tlast)
  );

  // Pack the result beat
  assign m_tdata = {6'd0, allele_count, group_id};

endmodule

FILE: src/ggac_checker.sv
// Port-level checks of the allele counter, bound to the top level.
// Depends only on the top level's ports.
module ggac_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [12:0] cfg_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // No input is taken while a row's results are still draining
  a_drain_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready during drain");

  // Drained group ids advance by one
  a_group_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && m_tdata[3:0] == 4'($past(m_tdata[3:0]) + 4'd1))
    else $error("group ids out of order");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind grouped_genotype_allele_counter_core ggac_checker u_ggac_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for grouped_genotype_allele_counter_core: predicts the
// per-group allele counts of every row and checks the output beats in order.
// Depends on ggac_pkg and the core; drives both streams with random gaps.
module tb_top;

  localparam int unsigned TABLE_DEPTH    = 4096;
  localparam int unsigned GROUP_CAP      = 16;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned IDLE_SETTLE    = 8;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned RANDOM_BEATS   = 430;
  localparam int unsigned TOP_BYTES      = 6;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  // One-based labels for the opening load beats: in range, zero, and past the top
  localparam logic [ggac_pkg::GVAL_W-1:0] SEED_LABELS [16] = '{
    5'd1, 5'd2, 5'd3, 5'd4, 5'd1, 5'd0, 5'd2, 5'd16,
    5'd3, 5'd31, 5'd4, 5'd17, 5'd1, 5'd2, 5'd3, 5'd4
  };

  typedef struct packed {
    logic [ggac_pkg::GID_W-1:0]   gid;
    logic [ggac_pkg::COUNT_W-1:0] count;
    logic                         last;
  } count_beat_t;

  // Tracks the label table, row counters and registers; queues the counts due
  class group_count_board;
    logic [ggac_pkg::LABEL_W-1:0] label_of [TABLE_DEPTH];
    logic [ggac_pkg::COUNT_W-1:0] tally [GROUP_CAP];
    int unsigned                  row_byte;
    logic [ggac_pkg::NIND_W-1:0]  nind_reg;
    logic [ggac_pkg::NGRP_W-1:0]  ngrp_reg;
    count_beat_t                  due_counts [$];
    int unsigned                  errors;

    function new();
      foreach (tally[g]) tally[g] = '0;
      row_byte = 0;
      nind_reg = 13'd4096;
      ngrp_reg = 5'd16;
      errors   = 0;
    endfunction

    function void set_reg(input logic idx, input logic [ggac_pkg::CFG_W-1:0] val);
      if (idx == ggac_pkg::CFG_NUM_IND) nind_reg = val[ggac_pkg::NIND_W-1:0];
      else ngrp_reg = val[ggac_pkg::NGRP_W-1:0];
    endfunction

    function int unsigned row_individuals();
      if (nind_reg == 0) return 1;
      if (nind_reg > TABLE_DEPTH) return TABLE_DEPTH;
      return nind_reg;
    endfunction

    function int unsigned row_groups();
      if (ngrp_reg == 0) return 1;
      if (ngrp_reg > GROUP_CAP) return GROUP_CAP;
      return ngrp_reg;
    endfunction

    function int unsigned row_bytes();
      return (row_individuals() + 3) / 4;
    endfunction

    // Apply one accepted input beat; queue the row's counts when it closes
    function void take_beat(input logic cmd, input logic [ggac_pkg::GIDX_W-1:0] gidx,
                            input logic [ggac_pkg::GVAL_W-1:0] gval,
                            input logic [ggac_pkg::GENO_W-1:0] geno,
                            input logic flip);
      int unsigned n_ind;
      int unsigned n_grp;
      int unsigned who;
      logic [1:0] code;
      logic [1:0] weight;
      logic [ggac_pkg::LABEL_W-1:0] lbl;
      logic [ggac_pkg::COUNT_W:0] sum;
      count_beat_t beat;
      if (cmd == ggac_pkg::CMD_LOAD) begin
        label_of[gidx] = gval - 5'd1;
        return;
      end
      n_ind = row_individuals();
      n_grp = row_groups();
      for (int s = 0; s < ggac_pkg::LANES; s++) begin
        who = row_byte * ggac_pkg::LANES + s;
        if (who < n_ind) begin
          code = geno[2*s +: 2];
          if (code == ggac_pkg::CODE_MISSING) weight = 2'd0;
          else if (flip) weight = 2'd2 - code;
          else weight = code;
          lbl = label_of[who];
          if (lbl < n_grp) begin
            sum = {1'b0, tally[lbl]} + weight;
            tally[lbl] = (sum > ggac_pkg::COUNT_MAX) ? ggac_pkg::COUNT_MAX
                                                     : sum[ggac_pkg::COUNT_W-1:0];
          end
        end
      end
      if (row_byte + 1 < row_bytes()) begin
        row_byte++;
        return;
      end
      for (int g = 0; g < n_grp; g++) begin
        beat.gid   = g[ggac_pkg::GID_W-1:0];
        beat.count = tally[g];
        beat.last  = (g + 1 == n_grp);
        due_counts.push_back(beat);
      end
      foreach (tally[g]) tally[g] = '0;
      row_byte = 0;
    endfunction

    function void check_count(input logic [ggac_pkg::GID_W-1:0] gid,
                              input logic [ggac_pkg::COUNT_W-1:0] count,
                              input logic last);
      count_beat_t want;
      if (due_counts.size() == 0) begin
        $error("unexpected count beat: group_id %0d allele_count %0d last %0b",
               gid, count, last);
        errors++;
        return;
      end
      want = due_counts.pop_front();
      if (gid !== want.gid) begin
        $error("group_id: expected %0d, got %0d", want.gid, gid);
        errors++;
      end
      if (count !== want.count) begin
        $error("allele_count: expected %0d, got %0d", want.count, count);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return due_counts.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  // [11:0] group_index, [16:12] group_value, [24:17] packed_genotypes,
  // [25] flip, [31:26] zero
  logic [ggac_pkg::IN_DW-1:0]    s_tdata = '0;
  // [0] command
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  // [3:0] group_id, [17:4] allele_count, [23:18] zero
  logic [ggac_pkg::OUT_DW-1:0]   m_tdata;
  logic                          m_tlast;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [ggac_pkg::CFG_W-1:0]    cfg_data = '0;

  group_count_board counts_board;
  bit               loaded_map [TABLE_DEPTH];
  int unsigned      beats_sent = 0;
  bit               s_gap_on = 1'b1;
  bit               m_stall_on = 1'b1;
  int unsigned      m_hold = 0;
  int unsigned      quiet_cycles = 0;

  grouped_genotype_allele_counter_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ggac_pkg::CFG_W-1:0] pick_ind_reg();
    case ($urandom_range(0, 7))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd4;
      default: return $urandom_range(2, 64);
    endcase
  endfunction

  function automatic logic [ggac_pkg::CFG_W-1:0] pick_grp_reg();
    case ($urandom_range(0, 7))
      0: return 13'd0;
      1: return 13'd1;
      2: return 13'd16;
      3: return $urandom_range(17, 31);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  // Mostly labels of live groups, some that fall outside the current count
  function automatic logic [ggac_pkg::GVAL_W-1:0] pick_label();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, counts_board.row_groups());
    return $urandom_range(0, 31);
  endfunction

  // Receiver: hold tready low for random stretches
  always @(negedge clk) begin
    if (m_hold != 0) begin
      m_tready <= 1'b0;
      m_hold <= m_hold - 1;
    end else begin
      m_tready <= 1'b1;
      if (m_stall_on && $urandom_range(0, 3) == 0) m_hold <= pick_gap();
    end
  end

  // Check every accepted count beat
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      counts_board.check_count(m_tdata[ggac_pkg::GID_W-1:0],
                               m_tdata[ggac_pkg::GID_W +: ggac_pkg::COUNT_W], m_tlast);
  end

  // Abort when neither stream moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one beat after a random gap and hold it until taken
  task automatic send_beat(input logic cmd, input logic [ggac_pkg::GIDX_W-1:0] gidx,
                           input logic [ggac_pkg::GVAL_W-1:0] gval,
                           input logic [ggac_pkg::GENO_W-1:0] geno,
                           input logic flip);
    int unsigned gap;
    gap = s_gap_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'd0, flip, geno, gval, gidx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    counts_board.take_beat(cmd, gidx, gval, geno, flip);
    beats_sent++;
  endtask

  task automatic send_load(input logic [ggac_pkg::GIDX_W-1:0] gidx,
                           input logic [ggac_pkg::GVAL_W-1:0] gval);
    loaded_map[gidx] = 1'b1;
    send_beat(ggac_pkg::CMD_LOAD, gidx, gval, $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  task automatic send_geno(input logic [ggac_pkg::GENO_W-1:0] geno, input logic flip);
    send_beat(ggac_pkg::CMD_GENO, $urandom_range(0, TABLE_DEPTH - 1), $urandom_range(0, 31),
              geno, flip);
  endtask

  // Load every missing table entry below n so a row never reads one unwritten
  task automatic ensure_fill(input int unsigned n);
    for (int i = 0; i < n; i++)
      if (!loaded_map[i]) send_load(i, pick_label());
  endtask

  // Finish the current row, with table writes mixed in
  task automatic send_row();
    logic flip;
    flip = $urandom_range(0, 1);
    do begin
      if ($urandom_range(0, 4) == 0) send_load($urandom_range(0, TABLE_DEPTH - 1), pick_label());
      if ($urandom_range(0, 9) == 0) flip = !flip;
      send_geno($urandom_range(0, 255), flip);
    end while (counts_board.row_byte != 0);
  endtask

  // Drop valid, wait for all counts to drain, then let the core settle
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (counts_board.outstanding() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [ggac_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    counts_board.set_reg(idx, val);
  endtask

  initial begin : stimulus
    int unsigned base;
    int unsigned part;
    logic [ggac_pkg::CFG_W-1:0] ind_val;
    counts_board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short row with a partial last byte, odd labels, every code with both flips
    write_reg(ggac_pkg::CFG_NUM_IND, 13'd13);
    write_reg(ggac_pkg::CFG_NUM_GRP, 13'd4);
    for (int i = 0; i < 16; i++) send_load(i, SEED_LABELS[i]);
    send_load(12'd4095, 5'd16);
    send_geno(8'h00, 1'b1);
    send_geno(8'hE4, 1'b0);
    send_geno(8'hE4, 1'b1);
    send_geno(8'hFF, 1'b0);

    // Both registers below range: one individual, one group
    settle();
    write_reg(ggac_pkg::CFG_NUM_IND, 13'd0);
    write_reg(ggac_pkg::CFG_NUM_GRP, 13'd0);
    send_geno(8'h02, 1'b0);

    // Group register above range
    settle();
    write_reg(ggac_pkg::CFG_NUM_IND, 13'd5);
    write_reg(ggac_pkg::CFG_NUM_GRP, 13'd31);
    send_geno(8'h55, 1'b0);
    send_geno(8'hAB, 1'b1);

    // Random phases; a partial row may be cut short by the next setting
    base = beats_sent;
    while (beats_sent - base < RANDOM_BEATS) begin
      settle();
      if (counts_board.row_byte != 0 && $urandom_range(0, 1) == 1)
        ind_val = $urandom_range(0, ggac_pkg::LANES * counts_board.row_byte);
      else
        ind_val = pick_ind_reg();
      write_reg(ggac_pkg::CFG_NUM_IND, ind_val);
      write_reg(ggac_pkg::CFG_NUM_GRP, pick_grp_reg());
      s_gap_on   = ($urandom_range(0, 3) != 0);
      m_stall_on = ($urandom_range(0, 3) != 0);
      ensure_fill(counts_board.row_individuals());
      repeat ($urandom_range(1, 5)) send_row();
      if (counts_board.row_bytes() > 1 && $urandom_range(0, 2) == 0) begin
        part = $urandom_range(1, counts_board.row_bytes() - 1);
        repeat (part) send_geno($urandom_range(0, 255), $urandom_range(0, 1));
      end
    end

    // Registers at their top codes and at the nominal maximum: run a few bytes
    // of a long row, then shrink the row so the next byte closes it
    settle();
    s_gap_on   = 1'b1;
    m_stall_on = 1'b1;
    write_reg(ggac_pkg::CFG_NUM_IND, 13'd8191);
    write_reg(ggac_pkg::CFG_NUM_GRP, 13'd31);
    ensure_fill(ggac_pkg::LANES * (counts_board.row_byte + TOP_BYTES + 2));
    repeat (TOP_BYTES) send_geno($urandom_range(0, 255), $urandom_range(0, 1));
    settle();
    write_reg(ggac_pkg::CFG_NUM_IND, 13'd4096);
    write_reg(ggac_pkg::CFG_NUM_GRP, 13'd16);
    repeat (2) send_geno($urandom_range(0, 255), $urandom_range(0, 1));
    settle();
    write_reg(ggac_pkg::CFG_NUM_IND, 13'd6);
    send_row();

    // Drain and wrap up
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (counts_board.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (counts_board.errors == 0 && counts_board.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
